// ===== hdl/tmlc_pkg.sv =====
// Shared types, constants and register codes of the thermal mitigation level controller.
package tmlc_pkg;

   // Field widths
   localparam int TempW  = 16;
   localparam int BiasW  = TempW + 1;
   localparam int OffW   = 12;
   localparam int CoolW  = 16;
   localparam int FreqW  = 24;
   localparam int TimeW  = 32;
   localparam int LevelW = 2;

   // Configuration port
   localparam int CsrIndexW = 4;
   localparam int CsrDataW  = 24;

   localparam logic [CsrIndexW-1:0] RegHighThreshold   = 4'd0;
   localparam logic [CsrIndexW-1:0] RegLowThreshold    = 4'd1;
   localparam logic [CsrIndexW-1:0] RegBandTwoOffset   = 4'd2;
   localparam logic [CsrIndexW-1:0] RegBandThreeOffset = 4'd3;
   localparam logic [CsrIndexW-1:0] RegCooldownSeconds = 4'd4;
   localparam logic [CsrIndexW-1:0] RegMaxFrequencyKhz = 4'd5;
   localparam logic [CsrIndexW-1:0] RegBiasTrigger     = 4'd6;
   localparam logic [CsrIndexW-1:0] RegBiasAmount      = 4'd7;

   // Register reset values
   localparam logic signed [TempW-1:0] HighThresholdReset   = 16'sd880;
   localparam logic signed [TempW-1:0] LowThresholdReset    = 16'sd800;
   localparam logic [OffW-1:0]         BandTwoOffsetReset   = 12'd32;
   localparam logic [OffW-1:0]         BandThreeOffsetReset = 12'd80;
   localparam logic [CoolW-1:0]        CooldownReset        = 16'd8;
   localparam logic [FreqW-1:0]        MaxFrequencyReset    = 24'd0;
   localparam logic [OffW-1:0]         BiasTriggerReset     = 12'd32;
   localparam logic [OffW-1:0]         BiasAmountReset      = 12'd16;

   // Mitigation levels
   localparam logic [LevelW-1:0] LevelNone  = 2'd0;
   localparam logic [LevelW-1:0] LevelOne   = 2'd1;
   localparam logic [LevelW-1:0] LevelTwo   = 2'd2;
   localparam logic [LevelW-1:0] LevelThree = 2'd3;

   // Divide by ten: (n * Recip10) >> Recip10Shift is exact for any 32 bit n
   localparam int              ScaledW      = FreqW + 3;
   localparam int              RecipW       = 32;
   localparam int              ProdW        = ScaledW + RecipW;
   localparam logic [RecipW-1:0] Recip10    = 32'hCCCC_CCCD;
   localparam int              Recip10Shift = 35;

   // Queue between front and back
   localparam int QueueDepthDefault = 2;

   typedef struct packed {
      logic signed [TempW-1:0] high_threshold;
      logic signed [TempW-1:0] low_threshold;
      logic [OffW-1:0]         band_two_offset;
      logic [OffW-1:0]         band_three_offset;
      logic [CoolW-1:0]        cooldown_seconds;
      logic [FreqW-1:0]        max_frequency_khz;
      logic [OffW-1:0]         bias_trigger;
      logic [OffW-1:0]         bias_amount;
   } cfg_type;

   // One classified sample
   typedef struct packed {
      logic              sample_valid;
      logic [LevelW-1:0] target;
      logic              below_band_two;
      logic              below_high;
      logic              below_low;
      logic [TimeW-1:0]  now_seconds;
   } entry_type;

   // Queue handshake seen by one side
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ===== hdl/tmlc_front.sv =====
// Front end: accepts samples, applies the prediction bias and classifies against the bands.
module tmlc_front (
   input  logic                         clock,
   input  logic                         reset,
   input  tmlc_pkg::cfg_type            cfg,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic                         in_sample_valid,
   input  logic signed [tmlc_pkg::TempW-1:0] in_measured,
   input  logic signed [tmlc_pkg::TempW-1:0] in_predicted,
   input  logic [tmlc_pkg::TimeW-1:0]   in_now,
   input  tmlc_pkg::qstat_type          qstat,
   output logic                         push,
   output tmlc_pkg::entry_type          push_entry
);

   logic                                 a_valid_ff, a_valid_in;
   logic                                 a_sample_ff;
   logic signed [tmlc_pkg::BiasW-1:0]    a_pred_ff, a_pred_in;
   logic [tmlc_pkg::TimeW-1:0]           a_now_ff;
   logic                                 fire;
   logic signed [tmlc_pkg::BiasW-1:0]    diff;
   logic signed [tmlc_pkg::BiasW-1:0]    hi;
   logic signed [tmlc_pkg::BiasW-1:0]    hi_two;
   logic signed [tmlc_pkg::BiasW-1:0]    hi_three;
   logic signed [tmlc_pkg::BiasW-1:0]    lo;

   // Take a word whenever the holding stage is empty or drains this cycle
   assign in_ready = !a_valid_ff || !qstat.full;
   assign fire     = in_valid && in_ready;
   assign push     = a_valid_ff && !qstat.full;

   // Bias the prediction when it runs too far ahead of the measurement
   always_comb begin
      diff = tmlc_pkg::BiasW'(in_predicted) - tmlc_pkg::BiasW'(in_measured);
      a_pred_in = tmlc_pkg::BiasW'(in_predicted);
      if (diff > $signed({5'b0, cfg.bias_trigger})) begin
         a_pred_in = a_pred_in + $signed({5'b0, cfg.bias_amount});
      end
   end

   assign a_valid_in = fire || (a_valid_ff && qstat.full);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   // Hold the biased sample until the queue takes it
   always_ff @(posedge clock) begin
      if (fire) begin
         a_sample_ff <= in_sample_valid;
         a_pred_ff   <= a_pred_in;
         a_now_ff    <= in_now;
      end
   end

   // Classify against the thresholds and hysteresis bands
   always_comb begin
      hi       = tmlc_pkg::BiasW'(cfg.high_threshold);
      lo       = tmlc_pkg::BiasW'(cfg.low_threshold);
      hi_two   = hi + $signed({5'b0, cfg.band_two_offset});
      hi_three = hi + $signed({5'b0, cfg.band_three_offset});

      push_entry.sample_valid   = a_sample_ff;
      push_entry.now_seconds    = a_now_ff;
      push_entry.below_band_two = a_pred_ff < hi_two;
      push_entry.below_high     = a_pred_ff < hi;
      push_entry.below_low      = a_pred_ff < lo;
      if (a_pred_ff > hi_three) begin
         push_entry.target = tmlc_pkg::LevelThree;
      end else if (a_pred_ff > hi_two) begin
         push_entry.target = tmlc_pkg::LevelTwo;
      end else if (a_pred_ff > hi) begin
         push_entry.target = tmlc_pkg::LevelOne;
      end else begin
         push_entry.target = tmlc_pkg::LevelNone;
      end
   end

endmodule

// ===== hdl/tmlc_queue.sv =====
// Short queue of classified samples between the front and back ends.
module tmlc_queue #(
   parameter int Depth = tmlc_pkg::QueueDepthDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tmlc_pkg::entry_type push_entry,
   input  logic                pop,
   output tmlc_pkg::entry_type pop_entry,
   output tmlc_pkg::qstat_type qstat
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   tmlc_pkg::entry_type mem [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_entry   = mem[rd_ptr_ff];
   assign qstat.full  = count_ff == CntW'(Depth);
   assign qstat.empty = count_ff == '0;

endmodule

// ===== hdl/tmlc_back.sv =====
// Back end: level state update, frequency cap scaling and the result register.
module tmlc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  tmlc_pkg::cfg_type             cfg,
   input  tmlc_pkg::qstat_type           qstat,
   input  tmlc_pkg::entry_type           pop_entry,
   output logic                          pop,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [tmlc_pkg::LevelW-1:0]   out_level,
   output logic                          out_cap_write,
   output logic [tmlc_pkg::FreqW-1:0]    out_cap_khz
);

   logic                           advance;
   logic [tmlc_pkg::LevelW-1:0]    level_ff, level_in;
   logic [tmlc_pkg::TimeW-1:0]     last_ff, last_in;
   logic                           wr;
   logic                           band;
   logic [tmlc_pkg::TimeW-1:0]     elapsed;
   logic                           s1_valid_ff;
   logic [tmlc_pkg::LevelW-1:0]    s1_level_ff;
   logic                           s1_wr_ff;
   logic                           o_valid_ff;
   logic [tmlc_pkg::LevelW-1:0]    o_level_ff;
   logic                           o_wr_ff;
   logic [tmlc_pkg::FreqW-1:0]     o_cap_ff, o_cap_in;
   logic [tmlc_pkg::ScaledW-1:0]   scaled;
   logic [tmlc_pkg::ProdW-1:0]     prod;

   // Move the back pipeline whenever the result register is free or being taken
   assign advance = !o_valid_ff || out_ready;
   assign pop     = advance && !qstat.empty;

   // Escalate at once if a max frequency is set; drop a level after cooldown in the release band
   always_comb begin
      level_in = level_ff;
      last_in  = last_ff;
      wr       = 1'b0;
      elapsed  = pop_entry.now_seconds - last_ff;
      case (level_ff)
         tmlc_pkg::LevelThree: band = pop_entry.below_band_two;
         tmlc_pkg::LevelTwo:   band = pop_entry.below_high;
         tmlc_pkg::LevelOne:   band = pop_entry.below_low;
         default:              band = 1'b0;
      endcase
      if (pop && pop_entry.sample_valid) begin
         if (pop_entry.target != tmlc_pkg::LevelNone) begin
            if (pop_entry.target > level_ff && cfg.max_frequency_khz != '0) begin
               level_in = pop_entry.target;
               wr       = 1'b1;
               last_in  = pop_entry.now_seconds;
            end
         end else if (band && elapsed >= tmlc_pkg::TimeW'(cfg.cooldown_seconds)) begin
            level_in = level_ff - 1'b1;
            wr       = cfg.max_frequency_khz != '0;
            last_in  = pop_entry.now_seconds;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= tmlc_pkg::LevelNone;
         last_ff     <= '0;
         s1_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else begin
         level_ff <= level_in;
         last_ff  <= last_in;
         if (advance) begin
            s1_valid_ff <= pop;
            o_valid_ff  <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_level_ff <= level_in;
         s1_wr_ff    <= wr;
      end
   end

   // Scale the maximum frequency for the new level: 70, 60, 50 or 100 percent
   always_comb begin
      if (s1_level_ff == tmlc_pkg::LevelOne) begin
         scaled = {cfg.max_frequency_khz, 2'b0} + {1'b0, cfg.max_frequency_khz, 1'b0}
                  + {3'b0, cfg.max_frequency_khz};
      end else begin
         scaled = {cfg.max_frequency_khz, 2'b0} + {1'b0, cfg.max_frequency_khz, 1'b0};
      end
      prod = tmlc_pkg::ProdW'(scaled) * tmlc_pkg::ProdW'(tmlc_pkg::Recip10);
      case (s1_level_ff)
         tmlc_pkg::LevelOne,
         tmlc_pkg::LevelTwo:   o_cap_in = prod[tmlc_pkg::Recip10Shift +: tmlc_pkg::FreqW];
         tmlc_pkg::LevelThree: o_cap_in = cfg.max_frequency_khz >> 1;
         default:              o_cap_in = cfg.max_frequency_khz;
      endcase
      if (!s1_wr_ff) begin
         o_cap_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         o_level_ff <= s1_level_ff;
         o_wr_ff    <= s1_wr_ff;
         o_cap_ff   <= o_cap_in;
      end
   end

   assign out_valid     = o_valid_ff;
   assign out_level     = o_level_ff;
   assign out_cap_write = o_wr_ff;
   assign out_cap_khz   = o_cap_ff;

endmodule

// ===== hdl/thermal_mitigation_level_controller.sv =====
// Top level of the thermal mitigation level controller: ports, registers and wiring.
// A req word passes the front holding register, the queue, stage one and the result register.
// Throughput: one sample per cycle unless rsp stalls; the level and timestamp update is a loop.
// A two-entry queue parts the classifying front from the back; rsp stalls fill it first.
// Reset (synchronous, active high) restores the register defaults, level zero, timestamp
// zero, and empties the pipeline and queue; no clearing pass is needed.
module thermal_mitigation_level_controller #(
   parameter int QueueDepth = tmlc_pkg::QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   // Input samples
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // measured_temp[15:0], predicted_temp[31:16], now_seconds[63:32]
   input  logic        req_tuser,   // sample_valid[0]
   // Results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // level[1:0], cap_khz[25:2], zero[31:26]
   output logic        rsp_tuser,   // cap_write[0]
   // Register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tmlc_pkg::CsrIndexW-1:0]    csr_index,
   input  logic [tmlc_pkg::CsrDataW-1:0]     csr_data
);

   tmlc_pkg::cfg_type    cfg_ff;
   tmlc_pkg::entry_type  push_entry, pop_entry;
   tmlc_pkg::qstat_type  qstat;
   logic                 push, pop;
   logic [tmlc_pkg::LevelW-1:0] out_level;
   logic [tmlc_pkg::FreqW-1:0]  out_cap_khz;

   assign csr_ready = 1'b1;

   // Write configuration registers; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.high_threshold    <= tmlc_pkg::HighThresholdReset;
         cfg_ff.low_threshold     <= tmlc_pkg::LowThresholdReset;
         cfg_ff.band_two_offset   <= tmlc_pkg::BandTwoOffsetReset;
         cfg_ff.band_three_offset <= tmlc_pkg::BandThreeOffsetReset;
         cfg_ff.cooldown_seconds  <= tmlc_pkg::CooldownReset;
         cfg_ff.max_frequency_khz <= tmlc_pkg::MaxFrequencyReset;
         cfg_ff.bias_trigger      <= tmlc_pkg::BiasTriggerReset;
         cfg_ff.bias_amount       <= tmlc_pkg::BiasAmountReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tmlc_pkg::RegHighThreshold:
               cfg_ff.high_threshold <= $signed(csr_data[tmlc_pkg::TempW-1:0]);
            tmlc_pkg::RegLowThreshold:
               cfg_ff.low_threshold <= $signed(csr_data[tmlc_pkg::TempW-1:0]);
            tmlc_pkg::RegBandTwoOffset:
               cfg_ff.band_two_offset <= csr_data[tmlc_pkg::OffW-1:0];
            tmlc_pkg::RegBandThreeOffset:
               cfg_ff.band_three_offset <= csr_data[tmlc_pkg::OffW-1:0];
            tmlc_pkg::RegCooldownSeconds:
               cfg_ff.cooldown_seconds <= csr_data[tmlc_pkg::CoolW-1:0];
            tmlc_pkg::RegMaxFrequencyKhz:
               cfg_ff.max_frequency_khz <= csr_data[tmlc_pkg::FreqW-1:0];
            tmlc_pkg::RegBiasTrigger:
               cfg_ff.bias_trigger <= csr_data[tmlc_pkg::OffW-1:0];
            tmlc_pkg::RegBiasAmount:
               cfg_ff.bias_amount <= csr_data[tmlc_pkg::OffW-1:0];
            default: ;
         endcase
      end
   end

   tmlc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .in_sample_valid (req_tuser),
      .in_measured     ($signed(req_tdata[15:0])),
      .in_predicted    ($signed(req_tdata[31:16])),
      .in_now          (req_tdata[63:32]),
      .qstat           (qstat),
      .push            (push),
      .push_entry      (push_entry)
   );

   tmlc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .qstat      (qstat)
   );

   tmlc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .qstat         (qstat),
      .pop_entry     (pop_entry),
      .pop           (pop),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_level     (out_level),
      .out_cap_write (rsp_tuser),
      .out_cap_khz   (out_cap_khz)
   );

   assign rsp_tdata = {6'b0, out_cap_khz, out_level};

endmodule

// ===== hdl/tmlc_checker.sv =====
// Port-level checks of the thermal mitigation level controller, bound to the top level.
module tmlc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   // A stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp word changed");

   // No cap value without a cap write
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[25:2] == 24'd0)
      else $error("cap value without cap write");

   // Reset empties the pipeline
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp word straight after reset");

   // Straight after reset no result can appear before a sample reaches the result register
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid ##1 !rsp_tvalid)
      else $error("rsp word too soon after reset");

endmodule

bind thermal_mitigation_level_controller tmlc_checker u_tmlc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/thermal_mitigation_level_controller_tb.sv =====
// Self-checking testbench for the thermal mitigation level controller: stream stimulus and result check.
module thermal_mitigation_level_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HalfPeriod  = 1;
   localparam int ResetCycles = 10;
   localparam int TailCycles  = 20;
   localparam int CycleLimit  = 1000000;
   localparam int WalkPhases  = 11;
   localparam int WalkItems   = 128;
   localparam int ReportLimit = 100;

   // One decision of the controller as it leaves on the rsp side
   typedef struct packed {
      logic [tmlc_pkg::LevelW-1:0] level;
      logic                        cap_write;
      logic [tmlc_pkg::FreqW-1:0]  cap_khz;
   } cap_decision_type;

   logic clock = 1'b0;
   logic reset;

   logic                           req_tvalid;
   logic                           req_tready;
   logic [63:0]                    req_tdata;
   logic                           req_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [31:0]                    rsp_tdata;
   logic                           rsp_tuser;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [tmlc_pkg::CsrIndexW-1:0] csr_index;
   logic [tmlc_pkg::CsrDataW-1:0]  csr_data;

   // Shadow copy of the controller registers and state
   tmlc_pkg::cfg_type           shadow_cfg;
   logic [tmlc_pkg::LevelW-1:0] shadow_level;
   logic [tmlc_pkg::TimeW-1:0]  shadow_last_action;
   cap_decision_type            awaited_decisions[$];

   int   mismatches       = 0;
   int   cycle_count      = 0;
   int   rsp_hold_request = 0;
   bit   req_idle         = 1'b0;
   bit   rsp_idle         = 1'b0;
   int   walk_temp;
   logic [tmlc_pkg::TimeW-1:0] walk_now;

   thermal_mitigation_level_controller u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(HalfPeriod) clock = ~clock;

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= ReportLimit)
         $display("MISMATCH @%0t: %s", $realtime, what);
   endtask

   function automatic int clamp_temp(input int v);
      if (v < -32768) return -32768;
      if (v > 32767) return 32767;
      return v;
   endfunction

   // Exact floor of the capped frequency for a level
   function automatic logic [tmlc_pkg::FreqW-1:0] level_cap(
         input logic [tmlc_pkg::LevelW-1:0] lvl);
      longint unsigned m;
      m = shadow_cfg.max_frequency_khz;
      case (lvl)
         tmlc_pkg::LevelOne:   m = (m * 7) / 10;
         tmlc_pkg::LevelTwo:   m = (m * 6) / 10;
         tmlc_pkg::LevelThree: m = m / 2;
         default:              ;
      endcase
      return m[tmlc_pkg::FreqW-1:0];
   endfunction

   // Advance the shadow controller by one sample and return its decision
   function automatic cap_decision_type decide_level(
         input logic ok,
         input logic [tmlc_pkg::TempW-1:0] meas_raw,
         input logic [tmlc_pkg::TempW-1:0] pred_raw,
         input logic [tmlc_pkg::TimeW-1:0] now);
      int meas, pred, hi, lo_th;
      logic [tmlc_pkg::LevelW-1:0] lvl, target;
      logic in_band;
      cap_decision_type d;
      d   = '0;
      lvl = shadow_level;
      if (ok) begin
         meas  = int'($signed(meas_raw));
         pred  = int'($signed(pred_raw));
         hi    = int'($signed(shadow_cfg.high_threshold));
         lo_th = int'($signed(shadow_cfg.low_threshold));
         // bias a prediction that runs well ahead of the measurement
         if (pred - meas > int'(shadow_cfg.bias_trigger))
            pred += int'(shadow_cfg.bias_amount);
         if (pred > hi + int'(shadow_cfg.band_three_offset))
            target = tmlc_pkg::LevelThree;
         else if (pred > hi + int'(shadow_cfg.band_two_offset))
            target = tmlc_pkg::LevelTwo;
         else if (pred > hi)
            target = tmlc_pkg::LevelOne;
         else
            target = tmlc_pkg::LevelNone;
         if (target != tmlc_pkg::LevelNone) begin
            // escalate at once, never without a known maximum frequency
            if (target > lvl && shadow_cfg.max_frequency_khz != '0) begin
               lvl                = target;
               d.cap_write        = 1'b1;
               d.cap_khz          = level_cap(lvl);
               shadow_last_action = now;
            end
         end else begin
            // release one level inside the hysteresis band after the cooldown
            case (lvl)
               tmlc_pkg::LevelThree:
                  in_band = pred < hi + int'(shadow_cfg.band_two_offset);
               tmlc_pkg::LevelTwo:   in_band = pred < hi;
               tmlc_pkg::LevelOne:   in_band = pred < lo_th;
               default:              in_band = 1'b0;
            endcase
            if (in_band &&
                (now - shadow_last_action) >= 32'(shadow_cfg.cooldown_seconds)) begin
               lvl = lvl - 2'd1;
               if (shadow_cfg.max_frequency_khz != '0) begin
                  d.cap_write = 1'b1;
                  d.cap_khz   = level_cap(lvl);
               end
               shadow_last_action = now;
            end
         end
         shadow_level = lvl;
      end
      d.level = lvl;
      return d;
   endfunction

   function automatic void store_register(input logic [tmlc_pkg::CsrIndexW-1:0] idx,
                                          input logic [tmlc_pkg::CsrDataW-1:0] value);
      case (idx)
         tmlc_pkg::RegHighThreshold:
            shadow_cfg.high_threshold    = value[tmlc_pkg::TempW-1:0];
         tmlc_pkg::RegLowThreshold:
            shadow_cfg.low_threshold     = value[tmlc_pkg::TempW-1:0];
         tmlc_pkg::RegBandTwoOffset:
            shadow_cfg.band_two_offset   = value[tmlc_pkg::OffW-1:0];
         tmlc_pkg::RegBandThreeOffset:
            shadow_cfg.band_three_offset = value[tmlc_pkg::OffW-1:0];
         tmlc_pkg::RegCooldownSeconds:
            shadow_cfg.cooldown_seconds  = value[tmlc_pkg::CoolW-1:0];
         tmlc_pkg::RegMaxFrequencyKhz:
            shadow_cfg.max_frequency_khz = value[tmlc_pkg::FreqW-1:0];
         tmlc_pkg::RegBiasTrigger:
            shadow_cfg.bias_trigger      = value[tmlc_pkg::OffW-1:0];
         tmlc_pkg::RegBiasAmount:
            shadow_cfg.bias_amount       = value[tmlc_pkg::OffW-1:0];
         default: ;
      endcase
   endfunction

   // Check each rsp word, then track register writes and predict each req word
   always @(posedge clock) begin
      cap_decision_type want;
      if (reset) begin
         shadow_cfg.high_threshold    = tmlc_pkg::HighThresholdReset;
         shadow_cfg.low_threshold     = tmlc_pkg::LowThresholdReset;
         shadow_cfg.band_two_offset   = tmlc_pkg::BandTwoOffsetReset;
         shadow_cfg.band_three_offset = tmlc_pkg::BandThreeOffsetReset;
         shadow_cfg.cooldown_seconds  = tmlc_pkg::CooldownReset;
         shadow_cfg.max_frequency_khz = tmlc_pkg::MaxFrequencyReset;
         shadow_cfg.bias_trigger      = tmlc_pkg::BiasTriggerReset;
         shadow_cfg.bias_amount       = tmlc_pkg::BiasAmountReset;
         shadow_level                 = tmlc_pkg::LevelNone;
         shadow_last_action           = '0;
         awaited_decisions.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_decisions.size() == 0) begin
               report_mismatch($sformatf("unexpected rsp word level=%0d cap_write=%0b cap=%0d",
                                         rsp_tdata[1:0], rsp_tuser, rsp_tdata[25:2]));
            end else begin
               want = awaited_decisions.pop_front();
               if (rsp_tdata[1:0] !== want.level || rsp_tuser !== want.cap_write ||
                   rsp_tdata[25:2] !== want.cap_khz)
                  report_mismatch($sformatf(
                     "level %0d/%0d cap_write %0b/%0b cap_khz %0d/%0d (got/expected)",
                     rsp_tdata[1:0], want.level, rsp_tuser, want.cap_write,
                     rsp_tdata[25:2], want.cap_khz));
            end
         end
         if (csr_valid && csr_ready)
            store_register(csr_index, csr_data);
         if (req_tvalid && req_tready)
            awaited_decisions.push_back(decide_level(req_tuser, req_tdata[15:0],
                                                     req_tdata[31:16], req_tdata[63:32]));
      end
   end

   // Idle length: mostly short, a few long
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 19);
      if (r < 15) return $urandom_range(1, 3);
      if (r < 19) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Drive rsp_tready: long hold-offs on request, random stalls otherwise when rsp_idle is set
   initial begin : rsp_side
      int hold_left;
      int stall_left;
      logic ready_next;
      hold_left  = 0;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request > 0) begin
            hold_left        = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
         end else if (rsp_idle && $urandom_range(0, 3) == 0) begin
            stall_left = gap_length() - 1;
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         rsp_tready <= ready_next;
      end
   end

   // Offer one sample word and hold it until accepted; returns at a falling edge
   task automatic send_sample(input logic ok, input logic [tmlc_pkg::TempW-1:0] meas,
                              input logic [tmlc_pkg::TempW-1:0] pred,
                              input logic [tmlc_pkg::TimeW-1:0] now);
      int gap;
      gap = (req_idle && $urandom_range(0, 2) == 0) ? gap_length() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= ok;
      req_tdata  <= {now, pred, meas};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Drop valid and hold until every awaited word has come back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (awaited_decisions.size() != 0) @(negedge clock);
   endtask

   // Write one register; bits above the field carry junk that must be dropped
   task automatic write_reg(input logic [tmlc_pkg::CsrIndexW-1:0] idx, input int value,
                            input int width);
      logic [31:0] word;
      word = ($urandom << width) | (32'(value) & ((32'd1 << width) - 1));
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= word[tmlc_pkg::CsrDataW-1:0];
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_all(input int hi, input int lo, input int b2, input int b3,
                            input int cd, input int mx, input int bt, input int ba);
      wait_for_results();
      write_reg(tmlc_pkg::RegHighThreshold, hi, tmlc_pkg::TempW);
      write_reg(tmlc_pkg::RegLowThreshold, lo, tmlc_pkg::TempW);
      write_reg(tmlc_pkg::RegBandTwoOffset, b2, tmlc_pkg::OffW);
      write_reg(tmlc_pkg::RegBandThreeOffset, b3, tmlc_pkg::OffW);
      write_reg(tmlc_pkg::RegCooldownSeconds, cd, tmlc_pkg::CoolW);
      write_reg(tmlc_pkg::RegMaxFrequencyKhz, mx, tmlc_pkg::FreqW);
      write_reg(tmlc_pkg::RegBiasTrigger, bt, tmlc_pkg::OffW);
      write_reg(tmlc_pkg::RegBiasAmount, ba, tmlc_pkg::OffW);
      walk_temp = int'($signed(shadow_cfg.high_threshold));
   endtask

   // Pick a random setting, mostly around realistic thresholds
   task automatic retune_settings();
      int hi, lo, b2, b3, cd, mx, bt, ba;
      hi = ($urandom_range(0, 7) == 0) ? $urandom : 400 + $urandom_range(0, 800);
      lo = ($urandom_range(0, 7) == 0) ? $urandom : hi - int'($urandom_range(0, 150));
      b2 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 64);
      b3 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : b2 + $urandom_range(0, 96);
      cd = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 12);
      if ($urandom_range(0, 5) == 0)
         mx = 0;
      else if ($urandom_range(0, 7) == 0)
         mx = 24'hFFFFFF;
      else
         mx = $urandom_range(1, 24'hFFFFFF);
      bt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 64);
      ba = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 64);
      write_all(hi, lo, b2, b3, cd, mx, bt, ba);
   endtask

   // Random walk of the temperature across the bands, with time moving on
   task automatic run_walk(input int count);
      int hi, lo_b, hi_b, meas, step_max;
      logic ok;
      for (int i = 0; i < count; i++) begin
         hi   = int'($signed(shadow_cfg.high_threshold));
         lo_b = int'($signed(shadow_cfg.low_threshold));
         lo_b = clamp_temp(((lo_b < hi) ? lo_b : hi) - 60);
         hi_b = clamp_temp(hi + int'(shadow_cfg.band_three_offset) + 60);
         if ($urandom_range(0, 29) == 0) begin
            // noise: any bit pattern at all
            send_sample(1'($urandom_range(0, 1)), tmlc_pkg::TempW'($urandom),
                        tmlc_pkg::TempW'($urandom), $urandom);
         end else begin
            walk_temp += int'($urandom_range(0, 60)) - 30;
            if (walk_temp < lo_b || walk_temp > hi_b || $urandom_range(0, 15) == 0)
               walk_temp = lo_b + int'($urandom_range(0, hi_b - lo_b));
            meas = clamp_temp(walk_temp + 2 -
                              int'($urandom_range(0, 2 * int'(shadow_cfg.bias_trigger) + 4)));
            step_max = (shadow_cfg.cooldown_seconds > 20) ? 20 :
                       int'(shadow_cfg.cooldown_seconds);
            walk_now += $urandom_range(0, step_max + 2);
            if ($urandom_range(0, 24) == 0)
               walk_now += $urandom_range(0, 70000);
            ok = ($urandom_range(0, 11) != 0);
            send_sample(ok, meas[tmlc_pkg::TempW-1:0], walk_temp[tmlc_pkg::TempW-1:0],
                        walk_now);
         end
      end
   endtask

   // Reset settings: no maximum frequency, so nothing may escalate
   task automatic test_unavailable_frequency();
      send_sample(1'b1, 900, 1000, 5);
      send_sample(1'b1, -32768, 32767, 6);
      send_sample(1'b0, 0, 0, 7);
      send_sample(1'b1, 32767, -32768, 32'hFFFF_FFFF);
      send_sample(1'b1, 0, -32768, 0);
   endtask

   // Escalate, hold through the cooldown, release band by band, bias edge
   task automatic test_escalation_and_release();
      wait_for_results();
      write_reg(tmlc_pkg::RegMaxFrequencyKhz, 1000000, tmlc_pkg::FreqW);
      write_reg(tmlc_pkg::RegCooldownSeconds, 4, tmlc_pkg::CoolW);
      send_sample(1'b1, 881, 881, 10);   // just above high threshold
      send_sample(1'b1, 900, 961, 11);   // biased straight to level three
      send_sample(1'b1, 900, 920, 12);   // lower target: no action
      send_sample(1'b0, 900, 2000, 13);  // invalid sample: echo only
      send_sample(1'b1, 800, 700, 14);   // cooldown not yet over
      send_sample(1'b1, 800, 700, 15);   // three to two
      send_sample(1'b1, 880, 880, 19);   // on the threshold: stay
      send_sample(1'b1, 870, 879, 19);   // two to one
      send_sample(1'b1, 800, 800, 30);   // on the release threshold: stay
      send_sample(1'b1, 799, 799, 30);   // one to none, full frequency back
      send_sample(1'b1, 848, 880, 31);   // excess equal to the trigger: no bias
      send_sample(1'b1, 847, 880, 32);   // excess above the trigger: biased up
   endtask

   // Elapsed time across the wrap of the seconds counter
   task automatic test_counter_wrap();
      wait_for_results();
      write_reg(tmlc_pkg::RegCooldownSeconds, 5, tmlc_pkg::CoolW);
      send_sample(1'b1, 0, 32767, 32'hFFFF_FFFE);
      send_sample(1'b1, 0, -32768, 2);
      send_sample(1'b1, 0, -32768, 3);
   endtask

   // Release still steps down with no frequency, but issues no cap
   task automatic test_release_without_frequency();
      wait_for_results();
      write_reg(tmlc_pkg::RegMaxFrequencyKhz, 0, tmlc_pkg::FreqW);
      send_sample(1'b1, 0, 0, 100);
      send_sample(1'b1, 0, 0, 110);
      send_sample(1'b1, 0, 2000, 111);
   endtask

   // Writes past the last register must change nothing
   task automatic test_unmapped_registers();
      wait_for_results();
      write_reg(tmlc_pkg::RegMaxFrequencyKhz, 3000000, tmlc_pkg::FreqW);
      for (int i = int'(tmlc_pkg::RegBiasAmount) + 1; i < (1 << tmlc_pkg::CsrIndexW); i++)
         write_reg(tmlc_pkg::CsrIndexW'(i), $urandom, 0);
      walk_temp = int'($signed(shadow_cfg.high_threshold));
      walk_now  = 200;
      run_walk(20);
   endtask

   // Corner settings of every register
   task automatic test_register_extremes();
      write_all(32767, -32768, 4095, 4095, 0, 24'hFFFFFF, 0, 4095);
      run_walk(40);
      write_all(-32768, -32768, 0, 0, 65535, 1, 4095, 0);
      run_walk(40);
      write_all(0, 0, 0, 4095, 1, 10, 4095, 4095);
      run_walk(40);
      write_all(-32768, 32767, 4095, 0, 3, 24'hFFFFFF, 0, 0);
      run_walk(40);
   endtask

   // Hold rsp off long enough to fill the block, then drain it completely
   task automatic test_output_backpressure();
      retune_settings();
      req_idle         = 1'b0;
      rsp_hold_request = 300;
      run_walk(40);
      wait_for_results();
   endtask

   // Random settings and walks, with idling switched per phase
   task automatic test_random_walks();
      for (int p = 0; p < WalkPhases; p++) begin
         retune_settings();
         req_idle = (p % 3 != 0);
         rsp_idle = (p % 4 != 1);
         run_walk(WalkItems);
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      walk_temp  = 0;
      walk_now   = '0;
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      req_idle = 1'b1;
      rsp_idle = 1'b1;
      test_unavailable_frequency();
      test_escalation_and_release();
      test_counter_wrap();
      test_release_without_frequency();
      test_unmapped_registers();
      test_register_extremes();
      test_output_backpressure();
      test_random_walks();

      wait_for_results();
      repeat (TailCycles) @(posedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
